@@ design/fnd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fnd_pkg - shared definitions for the four-neighbour despeckle filter
// Register codes, field widths, reset values and the front-to-back queue
// entry type.
// ----------------------------------------------------------------------------
package fnd_pkg;

  // Geometry limit of the line buffers (default of the top-level parameter)
  localparam int MAX_WIDTH_DEF = 63;

  // Field widths
  localparam int PIX_W      = 8;
  localparam int WIDTH_W    = 6;
  localparam int HEIGHT_W   = 11;
  localparam int THRESH_W   = 8;
  localparam int ROW_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_THRESHOLD = 2'd2;

  // Register reset values and geometry clamps
  localparam logic [WIDTH_W-1:0]  RESET_WIDTH     = 6'd30;
  localparam logic [HEIGHT_W-1:0] RESET_HEIGHT    = 11'd20;
  localparam logic [THRESH_W-1:0] RESET_THRESHOLD = 8'd1;
  localparam logic [WIDTH_W-1:0]  MIN_WIDTH       = 6'd3;
  localparam logic [HEIGHT_W-1:0] MIN_HEIGHT      = 11'd3;
  localparam logic [HEIGHT_W-1:0] MAX_HEIGHT      = 11'd1024;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QLVL_W      = 3;

  // One classified item on its way to the back end
  typedef struct packed {
    logic               has_out;   // carries a settled pixel of the row above
    logic               last_row;  // input pixel belongs to the final row
    logic               flush;     // final pixel of the frame
    logic [PIX_W-1:0]   pixel;     // settled pixel of the row above
    logic [PIX_W-1:0]   raw;       // raw input pixel
    logic [WIDTH_W-1:0] col;       // column of the input pixel
  } entry_t;

  // Head of the queue as seen by the back end
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

endpackage
`default_nettype wire

@@ design/fnd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fnd_front - input side of the despeckle filter
// Holds the configuration and raster position, keeps the raw and corrected
// line buffers, settles the pixel one row above each input and classifies
// the beat for the back end.
// ----------------------------------------------------------------------------
module fnd_front #(
  parameter int MAX_WIDTH = fnd_pkg::MAX_WIDTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire  [fnd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [fnd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [fnd_pkg::PIX_W-1:0]        pixel_in,
  input  wire  [fnd_pkg::QLVL_W-1:0]       queue_level,
  output logic                             push,
  output fnd_pkg::entry_t                  push_entry
);

  localparam int AW    = $clog2(MAX_WIDTH + 1);
  localparam int DEPTH = MAX_WIDTH + 1;
  localparam logic [fnd_pkg::WIDTH_W-1:0] WIDTH_CAP = fnd_pkg::WIDTH_W'(MAX_WIDTH);

  function automatic logic [fnd_pkg::PIX_W-1:0] abs_diff(
    input logic [fnd_pkg::PIX_W-1:0] a,
    input logic [fnd_pkg::PIX_W-1:0] b
  );
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Configuration registers
  logic [fnd_pkg::WIDTH_W-1:0]  image_width;
  logic [fnd_pkg::HEIGHT_W-1:0] image_height;
  logic [fnd_pkg::THRESH_W-1:0] diff_threshold;
  logic                         geom_write;

  // Raster position of the next input pixel
  logic [fnd_pkg::WIDTH_W-1:0]  col;
  logic [fnd_pkg::ROW_W-1:0]    row;

  logic [fnd_pkg::WIDTH_W-1:0]  eff_width;
  logic [fnd_pkg::HEIGHT_W-1:0] eff_height;
  logic [fnd_pkg::WIDTH_W-1:0]  col_right;
  logic [AW-1:0]                addr_here;
  logic [AW-1:0]                addr_right;
  logic                         last_col;
  logic                         last_row;
  logic                         accept;
  logic [fnd_pkg::QLVL_W:0]     pending;

  // Line buffers: raw previous row and corrected row before that
  logic [fnd_pkg::PIX_W-1:0]    raw_mem  [DEPTH];
  logic [fnd_pkg::PIX_W-1:0]    corr_mem [DEPTH];
  logic [fnd_pkg::PIX_W-1:0]    here_q;
  logic [fnd_pkg::PIX_W-1:0]    right_q;
  logic [fnd_pkg::PIX_W-1:0]    up_q;

  // Settle stage
  logic                         b_valid;
  logic                         b_has_out;
  logic                         b_interior;
  logic                         b_last_row;
  logic                         b_flush;
  logic [fnd_pkg::PIX_W-1:0]    b_pixel;
  logic [fnd_pkg::WIDTH_W-1:0]  b_col;
  logic [fnd_pkg::PIX_W-1:0]    last_out;
  logic                         outlier;
  logic [fnd_pkg::PIX_W+1:0]    nb_sum;
  logic [fnd_pkg::PIX_W-1:0]    result;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= fnd_pkg::RESET_WIDTH;
      image_height   <= fnd_pkg::RESET_HEIGHT;
      diff_threshold <= fnd_pkg::RESET_THRESHOLD;
    end else if (cfg_we) begin
      case (cfg_index)
        fnd_pkg::REG_IMAGE_WIDTH:    image_width    <= cfg_data[fnd_pkg::WIDTH_W-1:0];
        fnd_pkg::REG_IMAGE_HEIGHT:   image_height   <= cfg_data;
        fnd_pkg::REG_DIFF_THRESHOLD: diff_threshold <= cfg_data[fnd_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  assign geom_write = cfg_we && (cfg_index == fnd_pkg::REG_IMAGE_WIDTH ||
                                 cfg_index == fnd_pkg::REG_IMAGE_HEIGHT);

  // Clamp geometry to the supported range
  always_comb begin
    if (image_width < fnd_pkg::MIN_WIDTH) begin
      eff_width = fnd_pkg::MIN_WIDTH;
    end else if (image_width > WIDTH_CAP) begin
      eff_width = WIDTH_CAP;
    end else begin
      eff_width = image_width;
    end
    if (image_height < fnd_pkg::MIN_HEIGHT) begin
      eff_height = fnd_pkg::MIN_HEIGHT;
    end else if (image_height > fnd_pkg::MAX_HEIGHT) begin
      eff_height = fnd_pkg::MAX_HEIGHT;
    end else begin
      eff_height = image_height;
    end
  end

  assign last_col   = (col == eff_width - fnd_pkg::WIDTH_W'(1));
  assign last_row   = (fnd_pkg::HEIGHT_W'(row) == eff_height - fnd_pkg::HEIGHT_W'(1));
  assign col_right  = col + fnd_pkg::WIDTH_W'(1);
  assign addr_here  = col[AW-1:0];
  assign addr_right = col_right[AW-1:0];

  // Hold off input while the queue cannot take every beat in flight
  assign pending  = {1'b0, queue_level} + (fnd_pkg::QLVL_W + 1)'(b_valid);
  assign in_stall = (pending >= (fnd_pkg::QLVL_W + 1)'(fnd_pkg::QUEUE_DEPTH));
  assign accept   = in_valid && !in_stall;

  // Advance the raster position
  always_ff @(posedge clk) begin
    if (rst || geom_write) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row + fnd_pkg::ROW_W'(1);
      end else begin
        col <= col_right;
      end
    end
  end

  // Store the raw pixel, fetch here, right and up neighbours
  always_ff @(posedge clk) begin
    if (accept) begin
      raw_mem[addr_here] <= pixel_in;
      here_q             <= raw_mem[addr_here];
      right_q            <= raw_mem[addr_right];
      up_q               <= corr_mem[addr_here];
    end
  end

  // Carry the classified beat into the settle stage
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_has_out  <= (row != '0);
      b_interior <= (row >= fnd_pkg::ROW_W'(2)) && (col != '0) && !last_col;
      b_last_row <= last_row;
      b_flush    <= last_row && last_col;
      b_pixel    <= pixel_in;
      b_col      <= col;
    end
  end

  // Test all four neighbours, average with round half up
  assign outlier = (abs_diff(here_q, up_q)     > diff_threshold) &&
                   (abs_diff(here_q, b_pixel)  > diff_threshold) &&
                   (abs_diff(here_q, last_out) > diff_threshold) &&
                   (abs_diff(here_q, right_q)  > diff_threshold);
  assign nb_sum  = {2'b00, up_q} + {2'b00, b_pixel} + {2'b00, last_out} +
                   {2'b00, right_q} + (fnd_pkg::PIX_W + 2)'(2);
  assign result  = (b_interior && outlier) ? nb_sum[fnd_pkg::PIX_W+1:2] : here_q;

  // Keep the settled value as left neighbour and as next row's up neighbour
  always_ff @(posedge clk) begin
    if (b_valid && b_has_out) begin
      corr_mem[b_col[AW-1:0]] <= result;
      last_out                <= result;
    end
  end

  // Hand the beat to the queue when it produces anything downstream
  assign push                = b_valid && (b_has_out || b_last_row);
  assign push_entry.has_out  = b_has_out;
  assign push_entry.last_row = b_last_row;
  assign push_entry.flush    = b_flush;
  assign push_entry.pixel    = result;
  assign push_entry.raw      = b_pixel;
  assign push_entry.col      = b_col;

endmodule
`default_nettype wire

@@ design/fnd_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fnd_queue - short queue between front and back end
// Register-based first-in first-out of classified beats; reports its fill
// level to the front and its head to the back.
// ----------------------------------------------------------------------------
module fnd_queue (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          push,
  input  wire fnd_pkg::entry_t         push_entry,
  input  wire                          pop,
  output fnd_pkg::head_t               head,
  output logic [fnd_pkg::QLVL_W-1:0]   queue_level
);

  fnd_pkg::entry_t              slots [fnd_pkg::QUEUE_DEPTH];
  logic [fnd_pkg::QPTR_W-1:0]   wr_ptr;
  logic [fnd_pkg::QPTR_W-1:0]   rd_ptr;
  logic [fnd_pkg::QLVL_W-1:0]   level;

  // Store pushed beats
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + fnd_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + fnd_pkg::QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   level <= level + fnd_pkg::QLVL_W'(1);
        2'b01:   level <= level - fnd_pkg::QLVL_W'(1);
        default: level <= level;
      endcase
    end
  end

  assign head.valid  = (level != '0);
  assign head.entry  = slots[rd_ptr];
  assign queue_level = level;

endmodule
`default_nettype wire

@@ design/fnd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fnd_back - output side of the despeckle filter
// Drains the queue into the output register, keeps the raw final row and
// replays it at the end of the frame.
// ----------------------------------------------------------------------------
module fnd_back #(
  parameter int MAX_WIDTH = fnd_pkg::MAX_WIDTH_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire fnd_pkg::head_t           head,
  output logic                          pop,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [fnd_pkg::PIX_W-1:0]     pixel_out,
  output logic                          frame_last
);

  localparam int AW    = $clog2(MAX_WIDTH + 1);
  localparam int DEPTH = MAX_WIDTH + 1;

  logic [fnd_pkg::PIX_W-1:0]   row_mem [DEPTH];
  logic [fnd_pkg::PIX_W-1:0]   row_q;
  logic                        flushing;
  logic                        flushing_next;
  logic [fnd_pkg::WIDTH_W-1:0] flush_idx;
  logic [fnd_pkg::WIDTH_W-1:0] flush_idx_next;
  logic [fnd_pkg::WIDTH_W-1:0] flush_end;
  logic                        adv;

  assign adv = !out_valid || !out_stall;
  assign pop = !flushing && adv && head.valid;

  // Step through the final row during a flush
  always_comb begin
    flushing_next  = flushing;
    flush_idx_next = flush_idx;
    if (!flushing) begin
      flush_idx_next = '0;
      if (pop && head.entry.flush) begin
        flushing_next = 1'b1;
      end
    end else if (adv) begin
      if (flush_idx == flush_end) begin
        flushing_next  = 1'b0;
        flush_idx_next = '0;
      end else begin
        flush_idx_next = flush_idx + fnd_pkg::WIDTH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flushing  <= 1'b0;
      flush_idx <= '0;
    end else begin
      flushing  <= flushing_next;
      flush_idx <= flush_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.entry.flush) begin
      flush_end <= head.entry.col;
    end
  end

  // Capture the final row, prefetch the next pixel to replay
  always_ff @(posedge clk) begin
    if (pop && head.entry.last_row) begin
      row_mem[head.entry.col[AW-1:0]] <= head.entry.raw;
    end
    row_q <= row_mem[flush_idx_next[AW-1:0]];
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= flushing || (pop && head.entry.has_out);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (flushing) begin
        pixel_out  <= row_q;
        frame_last <= (flush_idx == flush_end);
      end else begin
        pixel_out  <= head.entry.pixel;
        frame_last <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/four_neighbour_despeckle.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// four_neighbour_despeckle - in-place four-neighbor outlier filter
// Streams a gray frame in raster order and replaces isolated outliers by the
// rounded average of their up, down, left and right neighbors.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------
//   input    | in_valid / in_stall    | pixel_in
//   output   | out_valid / out_stall  | pixel_out, frame_last
//   config   | cfg_we                 | cfg_index, cfg_data
//
// One pixel is accepted per clock while the queue has room. out_valid rises
// after the pixel one row below is accepted and passes the settle stage, then
// queue, then output register. The final pixel of a frame adds, after its own
// settled beat, one beat per column of the final row, replayed back to back
// from the back-end row buffer; the queue does not drain meanwhile, so once
// its four entries are full in_stall holds the input for the rest of the
// replay. Reset clears position and control state; the line buffers need no
// clearing. Output stalls back up through the four-entry queue before
// in_stall rises.
// ----------------------------------------------------------------------------
module four_neighbour_despeckle #(
  parameter int MAX_WIDTH = fnd_pkg::MAX_WIDTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire  [fnd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [fnd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [fnd_pkg::PIX_W-1:0]        pixel_in,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [fnd_pkg::PIX_W-1:0]        pixel_out,
  output logic                             frame_last
);

  logic                          push;
  fnd_pkg::entry_t               push_entry;
  logic                          pop;
  fnd_pkg::head_t                head;
  logic [fnd_pkg::QLVL_W-1:0]    queue_level;

  fnd_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel_in    (pixel_in),
    .queue_level (queue_level),
    .push        (push),
    .push_entry  (push_entry)
  );

  fnd_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_entry  (push_entry),
    .pop         (pop),
    .head        (head),
    .queue_level (queue_level)
  );

  fnd_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_out  (pixel_out),
    .frame_last (frame_last)
  );

endmodule
`default_nettype wire

@@ design/fnd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fnd_checker - port-level checks for the despeckle filter
// Watches the top-level ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module fnd_checker (
  input wire                           clk,
  input wire                           rst,
  input wire                           in_stall,
  input wire                           out_valid,
  input wire                           out_stall,
  input wire [fnd_pkg::PIX_W-1:0]      pixel_out,
  input wire                           frame_last
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(pixel_out) && $stable(frame_last))
    else $error("stalled result payload changed");

  // Input backpressure only while results are waiting downstream
  a_stall_backlog: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with nothing pending at the output");

  // The end-of-frame beat closes a contiguous replay of the final row
  a_last_in_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> $past(out_valid))
    else $error("frame end beat without preceding beat");

endmodule

bind four_neighbour_despeckle fnd_checker u_fnd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .pixel_out  (pixel_out),
  .frame_last (frame_last)
);
`default_nettype wire
